FILE: src/nret_pkg.sv
// Shared types, constants and the smoothing function of the neighbor RSSI table.
package nret_pkg;

  // Default number of table entries.
  localparam int unsigned ENTRIES_DEF = 16;

  // Request kinds.
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;

  // Most results a list request may return.
  localparam logic [4:0] MAX_RESULTS = 5'd16;

  // Reset value of the listing window in milliseconds.
  localparam logic [31:0] WINDOW_RESET = 32'd10000;

  // Value returned when a lookup finds no entry.
  localparam logic signed [7:0] LOOKUP_MISS_RSSI = -8'sd127;

  // One request beat.
  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        addr;
    logic signed [7:0]  sample_rssi;
    logic [31:0]        now_ms;
    logic [4:0]         list_limit;
  } nret_in_t;

  // One result beat.
  typedef struct packed {
    logic [15:0]        out_addr;
    logic signed [7:0]  out_rssi;
    logic               valid_res;
    logic               last;
  } nret_out_t;

  // One stored table entry.
  typedef struct packed {
    logic [15:0]        addr;
    logic signed [7:0]  avg;
    logic [31:0]        stamp;
  } nret_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic finish;
  } nret_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stall_req;
    logic fin_ok;
  } nret_sts_t;

  // Smoothed value (31*old + sample)/32, truncated toward zero, clamped to 8 bits.
  function automatic logic signed [7:0] blend(logic signed [7:0] prev,
                                              logic signed [7:0] sample);
    logic signed [13:0] o14;
    logic signed [13:0] s14;
    logic signed [13:0] acc;
    logic signed [13:0] q;
    o14 = 14'(prev);
    s14 = 14'(sample);
    acc = (o14 <<< 5) - o14 + s14;
    q = acc >>> 5;
    // Arithmetic shift floors; round negative inexact quotients toward zero.
    if (acc[13] && (acc[4:0] != 5'd0)) begin
      q = q + 14'sd1;
    end
    if (q > 14'sd127) begin
      q = 14'sd127;
    end
    if (q < -14'sd128) begin
      q = -14'sd128;
    end
    return q[7:0];
  endfunction

endpackage

FILE: src/nret_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nret_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/nret_ctrl.sv
// Controller: sequences the accept, the entry scan and the final step of each request.
module nret_ctrl #(
  parameter int unsigned ENTRIES = nret_pkg::ENTRIES_DEF,
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CntW = $clog2(ENTRIES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output nret_pkg::nret_cmd_t cmd_o,
  output logic                re_o,
  output logic [IdxW-1:0]     raddr_o,
  output logic [IdxW-1:0]     ev_idx_o,
  input  nret_pkg::nret_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] ev_idx_q, ev_idx_d;
  logic            ev_vld_q, ev_vld_d;
  logic            adv;

  // Next-state and command logic.
  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    ev_idx_d   = ev_idx_q;
    ev_vld_d   = ev_vld_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    re_o       = 1'b0;
    adv        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          rd_idx_d   = '0;
          ev_vld_d   = 1'b0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // The scan holds while a list result waits for the output register.
        adv        = !(ev_vld_q && sts_i.stall_req);
        cmd_o.eval = ev_vld_q && adv;
        if (adv) begin
          if (rd_idx_q < CntW'(ENTRIES)) begin
            re_o     = 1'b1;
            ev_idx_d = rd_idx_q[IdxW-1:0];
            ev_vld_d = 1'b1;
            rd_idx_d = rd_idx_q + 1'b1;
          end else begin
            ev_vld_d = 1'b0;
            state_d  = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        if (sts_i.fin_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign raddr_o  = rd_idx_q[IdxW-1:0];
  assign ev_idx_o = ev_idx_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_idx_q <= '0;
      ev_idx_q <= '0;
      ev_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      ev_idx_q <= ev_idx_d;
      ev_vld_q <= ev_vld_d;
    end
  end

`ifndef NO_ASSERTIONS
  // The read counter never runs past the table.
  a_rd_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_idx_q <= CntW'(ENTRIES))
    else $error("read index ran past the table");

  // An evaluated entry always has read data behind it.
  a_eval_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && rd_idx_q == CntW'(ENTRIES)) |-> ev_vld_q)
    else $error("scan ended without evaluating the last entry");
`endif

endmodule

FILE: src/nret_dp.sv
// Datapath: table storage, request registers, scan trackers and the output register.
module nret_dp #(
  parameter int unsigned ENTRIES = nret_pkg::ENTRIES_DEF,
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [31:0]         cfg_data_i,
  input  nret_pkg::nret_in_t  in_data_i,
  input  nret_pkg::nret_cmd_t cmd_i,
  input  logic                re_i,
  input  logic [IdxW-1:0]     raddr_i,
  input  logic [IdxW-1:0]     ev_idx_i,
  output nret_pkg::nret_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output nret_pkg::nret_out_t out_data_o
);

  localparam int unsigned EntW = $bits(nret_pkg::nret_entry_t);

  logic [31:0]           window_q;
  nret_pkg::nret_in_t    req_q;
  logic [ENTRIES-1:0]    vld_q;
  logic                  hit_q;
  logic [IdxW-1:0]       hit_idx_q;
  logic signed [7:0]     hit_avg_q;
  logic [IdxW-1:0]       old_idx_q;
  logic [31:0]           old_stamp_q;
  logic [4:0]            cnt_q;
  logic                  pend_vld_q;
  nret_pkg::nret_entry_t pend_q;
  logic                  out_vld_q;
  nret_pkg::nret_out_t   out_q, out_d;
  logic                  out_load;

  logic [EntW-1:0]       ram_rdata;
  nret_pkg::nret_entry_t entry;
  nret_pkg::nret_entry_t wdata;
  logic [IdxW-1:0]       waddr;
  logic                  we;
  logic                  is_update, is_lookup, is_list;
  logic                  qual, take, out_free;
  logic [4:0]            lim;

  // Window register; must be written only while the block is idle (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= nret_pkg::WINDOW_RESET;
    end else if (cfg_valid_i) begin
      window_q <= cfg_data_i;
    end
  end

  // Table storage.
  nret_ram #(
    .WIDTH (EntW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  // Request decode and evaluation of the entry under scan.
  always_comb begin
    is_update = (req_q.kind == nret_pkg::KIND_UPDATE);
    is_lookup = (req_q.kind == nret_pkg::KIND_LOOKUP);
    is_list   = (req_q.kind == nret_pkg::KIND_LIST);
    // An entry never written reads as empty.
    entry     = vld_q[ev_idx_i] ? nret_pkg::nret_entry_t'(ram_rdata) : '0;
    lim       = (req_q.list_limit > nret_pkg::MAX_RESULTS) ? nret_pkg::MAX_RESULTS
                                                           : req_q.list_limit;
    qual      = (entry.addr != 16'd0) && ((req_q.now_ms - entry.stamp) < window_q);
    take      = is_list && qual && (cnt_q < lim);
    out_free  = !out_vld_q || out_ready_i;
    sts_o.stall_req = take && pend_vld_q && !out_free;
    sts_o.fin_ok    = !(is_lookup || is_list) || out_free;
  end

  // Write of the final update step: blend on a hit, replace the oldest otherwise.
  always_comb begin
    we          = cmd_i.finish && is_update;
    waddr       = hit_q ? hit_idx_q : old_idx_q;
    wdata.addr  = req_q.addr;
    wdata.avg   = hit_q ? nret_pkg::blend(hit_avg_q, req_q.sample_rssi)
                        : req_q.sample_rssi;
    wdata.stamp = req_q.now_ms;
  end

  // Output register loads: a pushed list beat or the final beat of a lookup or list.
  always_comb begin
    out_load = 1'b0;
    out_d    = out_q;
    if (cmd_i.eval && take && pend_vld_q) begin
      out_load = 1'b1;
      out_d    = '{out_addr: pend_q.addr, out_rssi: pend_q.avg,
                   valid_res: 1'b1, last: 1'b0};
    end else if (cmd_i.finish && out_free && is_lookup) begin
      out_load = 1'b1;
      out_d    = '{out_addr: req_q.addr,
                   out_rssi: hit_q ? hit_avg_q : nret_pkg::LOOKUP_MISS_RSSI,
                   valid_res: hit_q, last: 1'b1};
    end else if (cmd_i.finish && out_free && is_list) begin
      out_load = 1'b1;
      if (pend_vld_q) begin
        out_d = '{out_addr: pend_q.addr, out_rssi: pend_q.avg,
                  valid_res: 1'b1, last: 1'b1};
      end else begin
        out_d = '{out_addr: 16'd0, out_rssi: 8'sd0, valid_res: 1'b0, last: 1'b1};
      end
    end
  end

  // Request payload and scan trackers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.eval) begin
      if (!hit_q && (entry.addr == req_q.addr)) begin
        hit_idx_q <= ev_idx_i;
        hit_avg_q <= entry.avg;
      end
      // Oldest stamp, strict compare so the lowest index wins ties.
      if ((ev_idx_i == '0) || (entry.stamp < old_stamp_q)) begin
        old_idx_q   <= ev_idx_i;
        old_stamp_q <= entry.stamp;
      end
      if (take) begin
        pend_q <= entry;
      end
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Control flags: valid bits, hit flag, list count, pending and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      hit_q      <= 1'b0;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        hit_q      <= 1'b0;
        cnt_q      <= '0;
        pend_vld_q <= 1'b0;
      end
      if (cmd_i.eval && (entry.addr == req_q.addr)) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.eval && take) begin
        cnt_q      <= cnt_q + 5'd1;
        pend_vld_q <= 1'b1;
      end
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // A result never overwrites a beat that has not been taken.
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_vld_q || out_ready_i))
    else $error("output register overwritten");

  // The list count stays within the result cap.
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= nret_pkg::MAX_RESULTS)
    else $error("list count beyond cap");

  // The table is never read and written in the same cycle.
  a_ram_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we && re_i))
    else $error("table read and write collide");
`endif

endmodule

FILE: src/neighbor_rssi_ewma_table_unit.sv
// Top level of the neighbor RSSI smoothing table.
//
// Requests enter on the in_* channel (valid/ready), one beat per request:
// update blends a sample into the entry for an address or replaces the
// entry with the oldest stamp, lookup returns one beat, list returns a beat per
// recent occupied entry up to its limit or one empty beat, the final one marked last.
// Results leave on the out_* channel (valid/ready) through an output register.
// The cfg_* channel writes the listing window; it is always ready. It must be
// written only while no request is in flight, which the block does not enforce.
// Each request passes through an accept step, a scan that reads each entry
// through the single read port of the table RAM and evaluates it after its
// read, and a final step for the table write or the last result beat.
// A new request is accepted once the previous one has finished, even while
// its last result still waits in the output register.
// When the receiver stalls, the list scan holds until the output register
// frees, and the final step waits likewise; no beat is lost.
// Reset empties the table through per-entry valid bits at once and sets the
// window to 10000 ms.
module neighbor_rssi_ewma_table_unit #(
  parameter int unsigned ENTRIES = nret_pkg::ENTRIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  nret_pkg::nret_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output nret_pkg::nret_out_t out_data_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  nret_pkg::nret_cmd_t cmd;
  nret_pkg::nret_sts_t sts;
  logic                re;
  logic [IdxW-1:0]     raddr;
  logic [IdxW-1:0]     ev_idx;

  // The window register takes a beat in any cycle.
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  nret_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .re_o       (re),
    .raddr_o    (raddr),
    .ev_idx_o   (ev_idx),
    .sts_i      (sts)
  );

  // Table and result logic.
  nret_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .re_i        (re),
    .raddr_i     (raddr),
    .ev_idx_i    (ev_idx),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
